// ===== design/uvs_pkg.sv =====
`default_nettype none

package uvs_pkg;

  // Build-time limits
  localparam int MAX_SEGMENTS = 255;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  // Field widths
  localparam int COUNT_W    = 8;
  localparam int RADIUS_W   = 15;
  localparam int IDX_W      = 17;
  localparam int POS_W      = 24;
  localparam int TURN_W     = 32;
  localparam int CW         = 34;   // CORDIC datapath, Q2.30 plus headroom
  localparam int DEN_W      = COUNT_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RADIUS_W;

  // Divider: numerator is lat << 32 or lon << 33 plus count, four quotient bits per stage
  localparam int DIV_NUM_W  = COUNT_W + 33;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = (DIV_NUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_PAD_W  = DIV_STAGES * DIV_BITS;

  // Sin/cos unit: fold, scale to radians, CORDIC steps, quadrant fix-up
  localparam int SC_LAT = CORDIC_N + 3;

  // Back pipeline depth: divider, sin/cos, trig product, radius product
  localparam int LAT = DIV_STAGES + SC_LAT + 2;

  localparam logic [30:0]          HALFPI_Q30   = 31'd1686629713;
  localparam logic signed [CW-1:0] GAIN_INV_Q30 = CW'(652032875);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS    = 2'd0,
    CFG_LAT_COUNT = 2'd1,
    CFG_LON_COUNT = 2'd2
  } uvs_cfg_e;

  typedef struct packed {
    logic [COUNT_W-1:0] lat_step;
    logic [COUNT_W-1:0] lon_step;
  } uvs_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0]        tri0_v0;
    logic [IDX_W-1:0]        tri0_v1;
    logic [IDX_W-1:0]        tri0_v2;
    logic [IDX_W-1:0]        tri1_v0;
    logic [IDX_W-1:0]        tri1_v1;
    logic [IDX_W-1:0]        tri1_v2;
  } uvs_out_t;

  // Classified grid point, held between front and back
  typedef struct packed {
    logic [COUNT_W-1:0] lat;
    logic [COUNT_W-1:0] lon;
    logic [COUNT_W-1:0] lat_n;
    logic [COUNT_W-1:0] lon_n;
    logic [IDX_W-1:0]   idx_a;
    logic [IDX_W-1:0]   idx_b;
  } uvs_item_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return CW'(v);
  endfunction

endpackage

`default_nettype wire

// ===== design/uv_sphere_vertex_generator_core.sv =====
// Path from the push transfer to out_o: the 2-entry queue, then
//   11 divider stages, 19 sin/cos stages and 2 product stages.
// Throughput: one grid point per cycle; set by the fully pipelined dividers
//   and CORDIC, which stall as a whole only while a result waits for pop.
// Reset (rst_ni low, asynchronous): queue and pipeline empty, radius 1,
//   latitude and longitude counts 16.
`default_nettype none

module uv_sphere_vertex_generator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes, only while idle
  input  logic                           cfg_we_i,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [uvs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // grid point side
  input  logic                           push,
  output logic                           full,
  input  uvs_pkg::uvs_in_t               in_i,
  // result side
  output logic                           empty,
  input  logic                           pop,
  output uvs_pkg::uvs_out_t              out_o
);

  uvs_pkg::uvs_item_t         front_item, q_item;
  logic [uvs_pkg::RADIUS_W-1:0] radius;
  logic                       q_empty, q_take, out_valid;

  // Front: config registers, clamping of steps and counts, quad indices
  uvs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .item_o     (front_item),
    .radius_o   (radius)
  );

  // Short queue decoupling front and back; push transfer lands here
  uvs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (q_take),
    .data_o  (q_item),
    .empty_o (q_empty)
  );

  // Back: angle division, CORDIC, scaling by radius; last stage is the output register
  uvs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (q_item),
    .item_valid_i (!q_empty),
    .item_take_o  (q_take),
    .radius_i     (radius),
    .out_o        (out_o),
    .out_valid_o  (out_valid),
    .out_take_i   (pop)
  );

  assign empty = !out_valid;

endmodule

`default_nettype wire

// ===== design/uvs_front.sv =====
`default_nettype none

module uvs_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [uvs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  uvs_pkg::uvs_in_t               in_i,
  output uvs_pkg::uvs_item_t             item_o,
  output logic [uvs_pkg::RADIUS_W-1:0]   radius_o
);

  logic [uvs_pkg::RADIUS_W-1:0] radius_q;
  logic [uvs_pkg::COUNT_W-1:0]  lat_cnt_q;
  logic [uvs_pkg::COUNT_W-1:0]  lon_cnt_q;
  logic [uvs_pkg::COUNT_W-1:0]  lat_n, lon_n, lat_c, lon_c;
  logic [uvs_pkg::IDX_W-1:0]    idx_a;

  function automatic logic [uvs_pkg::COUNT_W-1:0] eff_count(
    input logic [uvs_pkg::COUNT_W-1:0] c
  );
    logic [uvs_pkg::COUNT_W-1:0] r;
    r = (c == '0) ? uvs_pkg::COUNT_W'(1) : c;
    if (int'(r) > uvs_pkg::MAX_SEGMENTS) r = uvs_pkg::COUNT_W'(uvs_pkg::MAX_SEGMENTS);
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= uvs_pkg::RADIUS_W'(1);
      lat_cnt_q <= uvs_pkg::COUNT_W'(16);
      lon_cnt_q <= uvs_pkg::COUNT_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        uvs_pkg::CFG_RADIUS:    radius_q  <= cfg_data_i;
        uvs_pkg::CFG_LAT_COUNT: lat_cnt_q <= cfg_data_i[uvs_pkg::COUNT_W-1:0];
        uvs_pkg::CFG_LON_COUNT: lon_cnt_q <= cfg_data_i[uvs_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign lat_n = eff_count(lat_cnt_q);
  assign lon_n = eff_count(lon_cnt_q);
  assign lat_c = (in_i.lat_step > lat_n) ? lat_n : in_i.lat_step;
  assign lon_c = (in_i.lon_step > lon_n) ? lon_n : in_i.lon_step;

  // a = lat*(M+1) + lon, b = a + M + 1, both modulo 2^17
  assign idx_a = uvs_pkg::IDX_W'(uvs_pkg::IDX_W'(lat_c) * (uvs_pkg::IDX_W'(lon_n) + 1'b1))
               + uvs_pkg::IDX_W'(lon_c);

  assign item_o.lat   = lat_c;
  assign item_o.lon   = lon_c;
  assign item_o.lat_n = lat_n;
  assign item_o.lon_n = lon_n;
  assign item_o.idx_a = idx_a;
  assign item_o.idx_b = idx_a + uvs_pkg::IDX_W'(lon_n) + 1'b1;
  assign radius_o     = radius_q;

endmodule

`default_nettype wire

// ===== design/uvs_queue.sv =====
`default_nettype none

module uvs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  uvs_pkg::uvs_item_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output uvs_pkg::uvs_item_t data_o,
  output logic               empty_o
);

  uvs_pkg::uvs_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

// ===== design/uvs_div.sv =====
`default_nettype none

module uvs_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [uvs_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [uvs_pkg::DEN_W-1:0]     den_i,
  output logic [uvs_pkg::TURN_W-1:0]    quo_o
);

  // Word holds unconsumed numerator bits at the top, quotient bits enter at the bottom
  logic [uvs_pkg::DIV_PAD_W-1:0] wrd_q [uvs_pkg::DIV_STAGES];
  logic [uvs_pkg::DEN_W-1:0]     rem_q [uvs_pkg::DIV_STAGES];
  logic [uvs_pkg::DEN_W-1:0]     den_q [uvs_pkg::DIV_STAGES];

  for (genvar s = 0; s < uvs_pkg::DIV_STAGES; s++) begin : g_stage
    logic [uvs_pkg::DIV_PAD_W-1:0] wrd_in, wrd_d;
    logic [uvs_pkg::DEN_W-1:0]     rem_in, rem_d, den_in;

    if (s == 0) begin : g_first
      assign wrd_in = uvs_pkg::DIV_PAD_W'(num_i);
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign wrd_in = wrd_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
    end

    always_comb begin
      logic [uvs_pkg::DEN_W:0] t;
      wrd_d = wrd_in;
      rem_d = rem_in;
      for (int k = 0; k < uvs_pkg::DIV_BITS; k++) begin
        t     = {rem_d, wrd_d[uvs_pkg::DIV_PAD_W-1]};
        wrd_d = {wrd_d[uvs_pkg::DIV_PAD_W-2:0], 1'b0};
        if (t >= {1'b0, den_in}) begin
          t        = t - {1'b0, den_in};
          wrd_d[0] = 1'b1;
        end
        rem_d = t[uvs_pkg::DEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        wrd_q[s] <= wrd_d;
        rem_q[s] <= rem_d;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = wrd_q[uvs_pkg::DIV_STAGES-1][uvs_pkg::TURN_W-1:0];

endmodule

`default_nettype wire

// ===== design/uvs_sincos.sv =====
`default_nettype none

module uvs_sincos (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [uvs_pkg::TURN_W-1:0]     turns_i,
  output logic signed [uvs_pkg::CW-1:0]  cos_o,
  output logic signed [uvs_pkg::CW-1:0]  sin_o
);

  localparam int CW = uvs_pkg::CW;
  localparam int N  = uvs_pkg::CORDIC_N;

  logic [29:0]           mag_q;
  logic                  neg_q;
  logic [1:0]            qa_q, qb_q;
  logic signed [CW-1:0]  z0_q;
  logic signed [CW-1:0]  cx_q [N];
  logic signed [CW-1:0]  cy_q [N];
  logic signed [CW-1:0]  cz_q [N];
  logic [1:0]            cq_q [N];
  logic signed [CW-1:0]  cos_q, sin_q;

  logic [31:0]        t;
  logic signed [30:0] res;
  logic [29:0]        mag;
  logic [60:0]        prod;
  logic [CW-1:0]      zr;

  // Fold into a quadrant and a residual of at most an eighth of a turn
  assign t    = turns_i + 32'h2000_0000;
  assign res  = $signed({1'b0, t[29:0]}) - 31'sd536870912;
  assign mag  = res[30] ? 30'(-res) : 30'(res);
  // Residual to radians, Q2.30, rounded half up on magnitude
  assign prod = 61'(61'(mag_q) * 61'(uvs_pkg::HALFPI_Q30)) + 61'(1 << 29);
  assign zr   = CW'(prod >> 30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag;
      neg_q <= res[30];
      qa_q  <= t[31:30];
      z0_q  <= neg_q ? -$signed(zr) : $signed(zr);
      qb_q  <= qa_q;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [CW-1:0] xin, yin, zin, xs, ys;
    logic [1:0]           qin;
    logic                 dir;

    if (i == 0) begin : g_first
      assign xin = uvs_pkg::GAIN_INV_Q30;
      assign yin = '0;
      assign zin = z0_q;
      assign qin = qb_q;
    end else begin : g_next
      assign xin = cx_q[i-1];
      assign yin = cy_q[i-1];
      assign zin = cz_q[i-1];
      assign qin = cq_q[i-1];
    end

    assign xs  = xin >>> i;
    assign ys  = yin >>> i;
    assign dir = !zin[CW-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cx_q[i] <= dir ? xin - ys : xin + ys;
        cy_q[i] <= dir ? yin + xs : yin - xs;
        cz_q[i] <= dir ? zin - uvs_pkg::atan_q30(i) : zin + uvs_pkg::atan_q30(i);
        cq_q[i] <= qin;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (cq_q[N-1])
        2'd0: begin
          cos_q <= cx_q[N-1];
          sin_q <= cy_q[N-1];
        end
        2'd1: begin
          cos_q <= -cy_q[N-1];
          sin_q <= cx_q[N-1];
        end
        2'd2: begin
          cos_q <= -cx_q[N-1];
          sin_q <= -cy_q[N-1];
        end
        default: begin
          cos_q <= cy_q[N-1];
          sin_q <= -cx_q[N-1];
        end
      endcase
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

`default_nettype wire

// ===== design/uvs_back.sv =====
`default_nettype none

module uvs_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  uvs_pkg::uvs_item_t           item_i,
  input  logic                         item_valid_i,
  output logic                         item_take_o,
  input  logic [uvs_pkg::RADIUS_W-1:0] radius_i,
  output uvs_pkg::uvs_out_t            out_o,
  output logic                         out_valid_o,
  input  logic                         out_take_i
);

  localparam int CW  = uvs_pkg::CW;
  localparam int LAT = uvs_pkg::LAT;
  localparam int PW  = CW + uvs_pkg::RADIUS_W + 1;
  localparam int PW_W = uvs_pkg::POS_W;

  logic [LAT-1:0]              vld_q;
  logic [uvs_pkg::IDX_W-1:0]   a_q [LAT];
  logic [uvs_pkg::IDX_W-1:0]   b_q [LAT];
  logic                        en;

  logic [uvs_pkg::DIV_NUM_W-1:0] num_th, num_ph;
  logic [uvs_pkg::TURN_W-1:0]    th, ph;
  logic signed [CW-1:0]          ct, st, cp, sp;
  logic signed [2*CW-1:0]        m_xz_x, m_xz_z;
  logic signed [CW-1:0]          px_q, py_q, pz_q;
  logic signed [PW_W-1:0]        sx_q, sy_q, sz_q;

  // Whole pipeline moves unless a finished result is being held
  assign en          = !vld_q[LAT-1] || out_take_i;
  assign item_take_o = en && item_valid_i;

  assign num_th = {1'b0, item_i.lat, 32'd0} | uvs_pkg::DIV_NUM_W'(item_i.lat_n);
  assign num_ph = {item_i.lon, 33'd0}       | uvs_pkg::DIV_NUM_W'(item_i.lon_n);

  uvs_div u_div_th (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_th),
    .den_i ({item_i.lat_n, 1'b0}),
    .quo_o (th)
  );

  uvs_div u_div_ph (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_ph),
    .den_i ({item_i.lon_n, 1'b0}),
    .quo_o (ph)
  );

  uvs_sincos u_sc_th (
    .clk_i   (clk_i),
    .en_i    (en),
    .turns_i (th),
    .cos_o   (ct),
    .sin_o   (st)
  );

  uvs_sincos u_sc_ph (
    .clk_i   (clk_i),
    .en_i    (en),
    .turns_i (ph),
    .cos_o   (cp),
    .sin_o   (sp)
  );

  function automatic logic signed [PW_W-1:0] scale_sat(
    input logic signed [CW-1:0]          q30,
    input logic [uvs_pkg::RADIUS_W-1:0]  r
  );
    logic signed [PW-1:0] p;
    p = PW'(q30) * $signed({1'b0, r});
    p = (p + PW'(1 << 21)) >>> 22;
    if (p[PW-1] && !(&p[PW-2:PW_W-1]))      return {1'b1, {(PW_W-1){1'b0}}};
    else if (!p[PW-1] && (|p[PW-2:PW_W-1])) return {1'b0, {(PW_W-1){1'b1}}};
    else                                    return p[PW_W-1:0];
  endfunction

  assign m_xz_x = (2*CW)'(st) * (2*CW)'(cp) + (2*CW)'(1 << 29);
  assign m_xz_z = (2*CW)'(st) * (2*CW)'(sp) + (2*CW)'(1 << 29);

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= CW'(m_xz_x >>> 30);
      pz_q <= CW'(m_xz_z >>> 30);
      py_q <= ct;
      sx_q <= scale_sat(px_q, radius_i);
      sy_q <= scale_sat(py_q, radius_i);
      sz_q <= scale_sat(pz_q, radius_i);
      a_q[0] <= item_i.idx_a;
      b_q[0] <= item_i.idx_b;
      for (int k = 1; k < LAT; k++) begin
        a_q[k] <= a_q[k-1];
        b_q[k] <= b_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], item_valid_i};
    end
  end

  assign out_valid_o   = vld_q[LAT-1];
  assign out_o.pos_x   = sx_q;
  assign out_o.pos_y   = sy_q;
  assign out_o.pos_z   = sz_q;
  assign out_o.tri0_v0 = a_q[LAT-1];
  assign out_o.tri0_v1 = b_q[LAT-1];
  assign out_o.tri0_v2 = a_q[LAT-1] + 1'b1;
  assign out_o.tri1_v0 = b_q[LAT-1];
  assign out_o.tri1_v1 = b_q[LAT-1] + 1'b1;
  assign out_o.tri1_v2 = a_q[LAT-1] + 1'b1;

endmodule

`default_nettype wire

// ===== design/uvs_checker.sv =====
`default_nettype none

module uvs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input uvs_pkg::uvs_out_t out_o
);

  logic [7:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 8'(push && !full) - 8'(pop && !empty);
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_o))
    else $error("held result changed");

  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_o.tri1_v0 == out_o.tri0_v1 && out_o.tri1_v2 == out_o.tri0_v2 &&
               out_o.tri0_v2 == out_o.tri0_v0 + 17'd1 &&
               out_o.tri1_v1 == out_o.tri0_v1 + 17'd1)
    else $error("triangle indices inconsistent");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> cnt_q != 8'd0)
    else $error("result without pending item");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> cnt_q >= 8'd2)
    else $error("full with fewer than two items in flight");

endmodule

bind uv_sphere_vertex_generator_core uvs_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .out_o  (out_o)
);

`default_nettype wire
